// ===== hw/rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the servo status packet receiver.
// ----------------------------------------------------------------------------
package ssp_pkg;

	// Default window depth in bytes
	localparam int MAX_FRAME_DEF = 64;

	// Shortest frame: header, id, length, error, checksum
	localparam int MIN_FRAME = 6;

	localparam logic [15:0] TIMEOUT_RESET = 16'd20;

	localparam logic [7:0] HDR_BYTE  = 8'hFF;
	localparam logic [7:0] ID_LIMIT  = 8'hFD;
	localparam logic [7:0] ERR_LIMIT = 8'h7F;

	// Input function codes
	localparam logic [1:0] FUNC_BYTE  = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_START = 2'd2;

	// Classified operation carried to the engine
	typedef enum logic [1:0] {
		OP_BYTE,
		OP_TICK,
		OP_START
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_CSUM    = 3'd1,
		STAT_ID      = 3'd2,
		STAT_DEV     = 3'd3,
		STAT_TIMEOUT = 3'd4
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] rx_byte;
		logic [7:0] expected_id;
	} item_t;

	typedef struct packed {
		logic [7:0] param_byte;
		logic [5:0] param_index;
		status_t    frame_status;
		logic [7:0] device_id;
		logic [7:0] device_error;
		logic       last;
	} result_t;

endpackage

// ===== hw/rtl/ssp_front.sv =====
// ----------------------------------------------------------------------------
// ssp_front
// Accepts input transactions, classifies the function code and holds the
// items in a two-entry queue for the engine. Unused function codes are dropped.
// ----------------------------------------------------------------------------
module ssp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [1:0]     func,
	input  logic [7:0]     rx_byte,
	input  logic [7:0]     expected_id,
	output logic           item_valid,
	output ssp_pkg::item_t item,
	input  logic           item_pop
);
	import ssp_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       known;
	logic       enq;
	logic       deq;
	op_t        op;

	// Classify the function code
	always_comb begin
		known = 1'b1;
		op    = OP_BYTE;
		case (func)
			FUNC_BYTE:  op = OP_BYTE;
			FUNC_TICK:  op = OP_TICK;
			FUNC_START: op = OP_START;
			default:    known = 1'b0;
		endcase
	end

	assign full       = (count_q == 2'd2);
	assign enq        = push && !full && known;
	assign item_valid = (count_q != 2'd0);
	assign deq        = item_pop && item_valid;
	assign item       = entry_q[rd_ptr_q];

	// Store classified items
	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[wr_ptr_q] <= '{op: op, rx_byte: rx_byte, expected_id: expected_id};
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ssp_resq.sv =====
// ----------------------------------------------------------------------------
// ssp_resq
// Two-entry result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module ssp_resq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	input  ssp_pkg::result_t res_in,
	output logic             res_full,
	output logic             empty,
	input  logic             pop,
	output ssp_pkg::result_t res_out
);
	import ssp_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       enq;
	logic       deq;

	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign enq      = res_push && !res_full;
	assign deq      = pop && !empty;
	assign res_out  = entry_q[rd_ptr_q];

	// Store results
	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[wr_ptr_q] <= res_in;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ssp_engine.sv =====
// ----------------------------------------------------------------------------
// ssp_engine
// Receive window and frame engine: appends bytes to a circular window, hunts
// for the header, validates it, checks the checksum, times out on ticks and emits results.
// ----------------------------------------------------------------------------
module ssp_engine #(
	parameter int MAX_FRAME = ssp_pkg::MAX_FRAME_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      timeout_q,
	input  logic             item_valid,
	input  ssp_pkg::item_t   item,
	output logic             item_pop,
	input  logic             res_full,
	output logic             res_push,
	output ssp_pkg::result_t res_in
);
	import ssp_pkg::*;

	localparam int AW    = $clog2(MAX_FRAME);
	localparam int FW    = $clog2(MAX_FRAME + 1);
	localparam int DEPTH = 1 << AW;
	localparam logic [FW-1:0] MAX_F  = FW'(MAX_FRAME);
	localparam logic [FW-1:0] MIN_F  = FW'(MIN_FRAME);
	localparam logic [8:0]    LEN_HI = 9'(MAX_FRAME - 4);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SRCH,
		ST_HREQ,
		ST_HDR,
		ST_SREQ,
		ST_SUM,
		ST_STAT,
		ST_PRD,
		ST_PWR
	} state_t;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	state_t        state_q;
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] need_q;
	logic [FW-1:0] cnt_q;
	logic [7:0]    awaited_q;
	logic [15:0]   tick_q;
	logic          active_q;
	logic [7:0]    prev_q;
	logic [7:0]    id_q;
	logic [7:0]    len_q;
	logic [7:0]    err_q;
	logic [7:0]    sum_q;
	logic [7:0]    par_q;
	status_t       st_q;

	logic [FW-1:0] pos;
	logic [FW-1:0] rd_off;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic [15:0]   tick_inc;
	logic [8:0]    poff;
	logic [8:0]    len4;
	logic [FW-1:0] need_new;
	logic          hdr_bad;
	logic [7:0]    npar;
	logic          par_last;
	logic          pair_hit;

	assign pos      = cnt_q - FW'(1);
	assign tick_inc = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
	assign poff     = {1'b0, par_q} + 9'd5;
	assign len4     = {1'b0, len_q} + 9'd4;
	assign need_new = len4[FW-1:0];
	assign hdr_bad  = (id_q > ID_LIMIT) || (rdata_q > ERR_LIMIT) || (len_q < 8'd2)
		|| ({1'b0, len_q} > LEN_HI);
	assign npar     = len_q - 8'd2;
	assign par_last = (par_q == npar - 8'd1);
	assign pair_hit = (pos != '0) && (prev_q == HDR_BYTE) && (rdata_q == HDR_BYTE);

	assign item_pop = (state_q == ST_IDLE) && item_valid;
	assign wr_en    = item_pop && (item.op == OP_BYTE) && active_q && (fill_q < MAX_F);
	assign wr_addr  = head_q + fill_q[AW-1:0];

	// Select the window offset to read
	always_comb begin
		case (state_q)
			ST_SCAN:        rd_off = '0;
			ST_HREQ,
			ST_SREQ:        rd_off = FW'(2);
			ST_PRD,
			ST_PWR:         rd_off = poff[FW-1:0];
			default:        rd_off = cnt_q;
		endcase
	end

	assign rd_addr = head_q + rd_off[AW-1:0];

	// Window memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= item.rx_byte;
		end
		rdata_q <= mem[rd_addr];
	end

	// Build the result transaction
	assign res_push = !res_full && ((state_q == ST_STAT) || (state_q == ST_PWR));

	always_comb begin
		res_in.param_byte   = (state_q == ST_PWR) ? rdata_q : 8'd0;
		res_in.param_index  = (state_q == ST_PWR) ? par_q[5:0] : 6'd0;
		res_in.frame_status = st_q;
		res_in.device_id    = id_q;
		res_in.device_error = err_q;
		res_in.last         = (state_q == ST_PWR) ? par_last : 1'b1;
	end

	// Frame engine sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			fill_q    <= '0;
			need_q    <= MIN_F;
			cnt_q     <= '0;
			awaited_q <= 8'd0;
			tick_q    <= 16'd0;
			active_q  <= 1'b0;
			prev_q    <= 8'd0;
			id_q      <= 8'd0;
			len_q     <= 8'd0;
			err_q     <= 8'd0;
			sum_q     <= 8'd0;
			par_q     <= 8'd0;
			st_q      <= STAT_OK;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item.op)
							OP_START: begin
								awaited_q <= item.expected_id;
								fill_q    <= '0;
								need_q    <= MIN_F;
								tick_q    <= 16'd0;
								active_q  <= 1'b1;
							end
							OP_TICK: begin
								if (active_q) begin
									tick_q <= tick_inc;
									if (tick_inc > timeout_q) begin
										active_q <= 1'b0;
										st_q     <= STAT_TIMEOUT;
										id_q     <= 8'd0;
										err_q    <= 8'd0;
										state_q  <= ST_STAT;
									end
								end
							end
							OP_BYTE: begin
								if (active_q) begin
									if (fill_q < MAX_F) begin
										fill_q <= fill_q + FW'(1);
									end
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				// Start a header hunt if enough bytes are held
				ST_SCAN: begin
					if ((fill_q < need_q) || (fill_q < FW'(2))) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= FW'(1);
						state_q <= ST_SRCH;
					end
				end
				// Walk the window one byte a cycle looking for the header pair
				ST_SRCH: begin
					prev_q <= rdata_q;
					cnt_q  <= cnt_q + FW'(1);
					if (pair_hit) begin
						if (pos == FW'(1)) begin
							state_q <= (fill_q < MIN_F) ? ST_IDLE : ST_HREQ;
						end else begin
							head_q  <= head_q + AW'(pos - FW'(1));
							fill_q  <= fill_q - (pos - FW'(1));
							state_q <= ST_SCAN;
						end
					end else if (pos == fill_q - FW'(1)) begin
						// No header: keep only the newest byte
						head_q  <= head_q + AW'(pos);
						fill_q  <= fill_q - pos;
						state_q <= ST_SCAN;
					end
				end
				ST_HREQ: begin
					cnt_q   <= FW'(3);
					state_q <= ST_HDR;
				end
				// Capture id, length and error, then validate the header
				ST_HDR: begin
					cnt_q <= cnt_q + FW'(1);
					if (pos == FW'(2)) begin
						id_q <= rdata_q;
					end else if (pos == FW'(3)) begin
						len_q <= rdata_q;
					end else begin
						err_q <= rdata_q;
						if (hdr_bad) begin
							head_q  <= head_q + AW'(1);
							fill_q  <= fill_q - FW'(1);
							state_q <= ST_SCAN;
						end else begin
							need_q  <= need_new;
							state_q <= (fill_q < need_new) ? ST_IDLE : ST_SREQ;
						end
					end
				end
				ST_SREQ: begin
					cnt_q   <= FW'(3);
					sum_q   <= 8'd0;
					state_q <= ST_SUM;
				end
				// Accumulate the checksum, then classify the frame
				ST_SUM: begin
					cnt_q <= cnt_q + FW'(1);
					if (pos == need_q - FW'(1)) begin
						active_q <= 1'b0;
						par_q    <= 8'd0;
						state_q  <= ST_STAT;
						if (rdata_q != ~sum_q) begin
							st_q <= STAT_CSUM;
						end else if (id_q != awaited_q) begin
							st_q <= STAT_ID;
						end else if (err_q != 8'd0) begin
							st_q <= STAT_DEV;
						end else begin
							st_q <= STAT_OK;
							if (len_q > 8'd2) begin
								state_q <= ST_PRD;
							end
						end
					end else begin
						sum_q <= sum_q + rdata_q;
					end
				end
				// Hold a status-only result until the queue takes it
				ST_STAT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PRD: begin
					state_q <= ST_PWR;
				end
				// Emit one parameter byte
				ST_PWR: begin
					if (!res_full) begin
						if (par_last) begin
							state_q <= ST_IDLE;
						end else begin
							par_q   <= par_q + 8'd1;
							state_q <= ST_PRD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Window fill never exceeds its depth
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_F)
		else $error("window fill beyond depth");

	// Needed frame length stays within the legal frame sizes
	a_need_range: assert property (@(posedge clk) disable iff (!arst_n)
		(need_q >= MIN_F) && (need_q <= MAX_F))
		else $error("needed frame length out of range");

	// Results only come out once the read has ended
	a_res_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !active_q)
		else $error("result emitted during an active read");

	// A start item clears the window and arms the read
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && (item.op == OP_START)) |=>
		((fill_q == '0) && active_q && (need_q == MIN_F) && (tick_q == 16'd0)))
		else $error("start did not reset the read");

endmodule

// ===== hw/rtl/servo_status_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// servo_status_packet_receiver
// Status frame receiver for a serial servo bus, with timeout register.
// ----------------------------------------------------------------------------
// Items enter through a two-entry queue and are worked on one at a time by the
// frame engine. A received byte goes back to idle after the scan state when
// the window is too short to scan; otherwise the header hunt walks the window
// through the single read port of the window memory at one byte a cycle, and
// each dropped byte or rejected header starts a new walk from the front of the
// window. A complete frame then passes through the header check and the
// checksum pass and emits its parameter bytes one at a time, stretched by any
// back-pressure on the result side. Results leave through a two-entry queue,
// so the engine can go on while the consumer holds off until that queue fills.
// The timeout register is written through timeout_we and timeout_ticks; the
// user must write it only while the block is idle, which the block itself
// does not enforce. It resets to 20 ticks.
module servo_status_packet_receiver #(
	parameter int MAX_FRAME = ssp_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  expected_id,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  param_byte,
	output logic [5:0]  param_index,
	output logic [2:0]  frame_status,
	output logic [7:0]  device_id,
	output logic [7:0]  device_error,
	output logic        last,
	input  logic        timeout_we,
	input  logic [15:0] timeout_ticks
);
	import ssp_pkg::*;

	logic [15:0] timeout_q;
	logic        item_valid;
	item_t       item;
	logic        item_pop;
	logic        res_full;
	logic        res_push;
	result_t     res_in;
	result_t     res_out;

	// Hold the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (timeout_we) begin
			timeout_q <= timeout_ticks;
		end
	end

	ssp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.rx_byte     (rx_byte),
		.expected_id (expected_id),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop)
	);

	ssp_engine #(
		.MAX_FRAME (MAX_FRAME)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.timeout_q  (timeout_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_in     (res_in)
	);

	ssp_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	// Unpack the result transaction onto its ports
	assign param_byte   = res_out.param_byte;
	assign param_index  = res_out.param_index;
	assign frame_status = res_out.frame_status;
	assign device_id    = res_out.device_id;
	assign device_error = res_out.device_error;
	assign last         = res_out.last;

endmodule
